>>> rtl/xcfr_pkg.sv
// Shared constants and result type for the xor-checked frame receiver.
package xcfr_pkg;

   localparam logic [7:0]  SOF_BYTE   = 8'hA5;
   localparam logic [15:0] VOLTAGE_ID = 16'h0001;
   localparam logic [3:0]  BCD_MAX    = 4'd9;

   // One result item as produced by the parser
   typedef struct packed {
      logic        frame_ok;
      logic [15:0] frame_id;
      logic [7:0]  data_first;
      logic [7:0]  data_second;
      logic        digits_valid;
      logic        voltage_updated;
      logic [13:0] target_tenths;
   } rsp_type;

endpackage

>>> rtl/xcfr_parser.sv
// Frame parser: phase tracking, running XOR, field capture and voltage target.
module xcfr_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic [7:0]       rx_byte,
   output xcfr_pkg::rsp_type rsp
);
   import xcfr_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_ID_LO  = 3'd1,
      PH_ID_HI  = 3'd2,
      PH_DATA_1 = 3'd3,
      PH_DATA_2 = 3'd4,
      PH_CHECK  = 3'd5
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  xor_ff, xor_in;
   logic [15:0] id_ff, id_in;
   logic [15:0] data_ff, data_in;
   logic [13:0] volt_ff, volt_in;

   logic [3:0]  n0, n1, n2, n3;
   logic        digits_ok;
   logic        check_ok;
   logic [13:0] bcd_value;

   // Split data into nibbles and convert the four BCD digits to binary
   assign n0 = data_ff[15:12];
   assign n1 = data_ff[11:8];
   assign n2 = data_ff[7:4];
   assign n3 = data_ff[3:0];
   assign digits_ok = (n0 <= BCD_MAX) && (n1 <= BCD_MAX) &&
                      (n2 <= BCD_MAX) && (n3 <= BCD_MAX);
   assign check_ok  = (phase_ff == PH_CHECK) && (xor_ff == rx_byte);
   assign bcd_value = {10'd0, n0} * 14'd1000 + {10'd0, n1} * 14'd100 +
                      {10'd0, n2} * 14'd10 + {10'd0, n3};

   // Next state per byte
   always_comb begin
      phase_in = phase_ff;
      xor_in   = xor_ff;
      id_in    = id_ff;
      data_in  = data_ff;
      volt_in  = volt_ff;
      case (phase_ff)
         PH_ID_LO: begin
            id_in    = {id_ff[15:8], rx_byte};
            xor_in   = xor_ff ^ rx_byte;
            phase_in = PH_ID_HI;
         end
         PH_ID_HI: begin
            id_in    = {rx_byte, id_ff[7:0]};
            xor_in   = xor_ff ^ rx_byte;
            phase_in = PH_DATA_1;
         end
         PH_DATA_1: begin
            data_in  = {rx_byte, data_ff[7:0]};
            xor_in   = xor_ff ^ rx_byte;
            phase_in = PH_DATA_2;
         end
         PH_DATA_2: begin
            data_in  = {data_ff[15:8], rx_byte};
            xor_in   = xor_ff ^ rx_byte;
            phase_in = PH_CHECK;
         end
         PH_CHECK: begin
            // a failed check byte is not retried as a start byte
            if (check_ok && digits_ok && (id_ff == VOLTAGE_ID)) begin
               volt_in = bcd_value;
            end
            xor_in   = 8'd0;
            phase_in = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
            if (rx_byte == SOF_BYTE) begin
               xor_in   = rx_byte;
               phase_in = PH_ID_LO;
            end
         end
      endcase
   end

   // Result for the byte now presented
   always_comb begin
      rsp.frame_ok        = check_ok;
      rsp.frame_id        = check_ok ? id_ff : 16'd0;
      rsp.data_first      = check_ok ? data_ff[15:8] : 8'd0;
      rsp.data_second     = check_ok ? data_ff[7:0] : 8'd0;
      rsp.digits_valid    = check_ok && digits_ok;
      rsp.voltage_updated = check_ok && digits_ok && (id_ff == VOLTAGE_ID);
      rsp.target_tenths   = volt_in;
   end

   // Advance control state on each processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         xor_ff   <= 8'd0;
         volt_ff  <= 14'd0;
      end else if (fire) begin
         phase_ff <= phase_in;
         xor_ff   <= xor_in;
         volt_ff  <= volt_in;
      end
   end

   // Capture frame fields, no reset needed
   always_ff @(posedge clock) begin
      if (fire) begin
         id_ff   <= id_in;
         data_ff <= data_in;
      end
   end

endmodule

>>> rtl/xor_checked_frame_receiver.sv
// Top level: input register, frame parser and result register on stream ports.
//
//   channel | dir | tdata                                   | tuser
//   req     | in  | [7:0] rx_byte                           | -
//   rsp     | out | id, data_first, data_second, tenths     | ok, digits, updated
//
// One byte per cycle sustained while results are taken; an item goes from the input register
// into the result register when the parser advances on it, and leaves it when taken;
// the input register and the result register sit around the single-pass parser.
// Synchronous reset clears both stage valids, the phase, the XOR and the target.
// A stalled result holds its register; the input stage keeps taking bytes
// until both stages are full, then req_tready drops.
module xor_checked_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] frame_id, [23:16] data_first,
                                    // [31:24] data_second, [45:32] target_tenths,
                                    // [47:46] zero
   output logic [2:0]  rsp_tuser    // [0] frame_ok, [1] digits_valid,
                                    // [2] voltage_updated
);
   import xcfr_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   rsp_type    out_ff;
   rsp_type    rsp_next;
   logic       advance;
   logic       req_fire;
   logic       rsp_fire;

   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   // Hold the accepted byte until the parser takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
      end
   end

   xcfr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .rx_byte (in_byte_ff),
      .rsp     (rsp_next)
   );

   // Load the result register, drop valid once the item is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_fire) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff.target_tenths, out_ff.data_second,
                        out_ff.data_first, out_ff.frame_id};
   assign rsp_tuser  = {out_ff.voltage_updated, out_ff.digits_valid, out_ff.frame_ok};

   // A voltage update only comes with a good frame of decimal digits
   a_update_needs_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[0] && rsp_tuser[1])
      else $error("voltage update without a valid digit frame");

   // Frame id and data fields are zero when no frame completed
   a_zero_when_no_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[31:0] == 32'd0 && !rsp_tuser[1])
      else $error("frame fields set without a matching check byte");

   // Target stays within four decimal digits
   a_target_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[45:32] <= 14'd9999)
      else $error("target voltage out of range");

   // A taken result with no new item behind it empties the register
   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !advance |=> !rsp_tvalid)
      else $error("result register kept valid after being taken");

endmodule
